/* src/lmph_pkg.sv */
// ----------------------------------------------------------------------------
// lmph_pkg: shared types and constants of the peak-hold LED level meter
// Holds the queue item type, the back-end state type, LED level constants
// and the dB-to-segment quantizer.
// ----------------------------------------------------------------------------
package lmph_pkg;

  localparam int ChanW      = 5;
  localparam int LevelW     = 4;
  localparam int SlotFieldW = 3;
  localparam int PressW     = 7;
  localparam int PortW      = 2;
  localparam int KeyW       = 3;
  localparam int CfgW       = 4;
  localparam int DbW        = 17;
  localparam int PairW      = 2 * LevelW;
  localparam int QueueDepth = 2;

  localparam logic [LevelW-1:0] ClipLevel   = 4'd12;
  localparam logic [LevelW-1:0] TopLevel    = 4'd11;
  localparam logic [PressW-1:0] RightFlag   = 7'h10;
  localparam logic [PairW-1:0]  UnknownPair = 8'hFF;
  localparam logic [CfgW-1:0]   PortEnRst   = 4'hF;

  // (dB + 62.5) * 256 offset and one 5 dB segment in 1/256 dB
  localparam int QuantOffset = 16000;
  localparam int QuantStep   = 1280;

  typedef struct packed {
    logic                  is_clear;
    logic [ChanW-1:0]      channel;
    logic [LevelW-1:0]     lvl_l;
    logic [LevelW-1:0]     lvl_r;
    logic [SlotFieldW-1:0] slot;
  } item_t;

  typedef enum logic {
    BK_FETCH,
    BK_UPDATE
  } back_state_e;

  // Map a Q8.8 dB level to segment 0..11, or 12 above 0 dB.
  function automatic logic [LevelW-1:0] quantize(input logic signed [DbW-1:0] x);
    logic signed [DbW:0] t;
    logic [LevelW-1:0]   lvl;
    t   = $signed({x[DbW-1], x}) + $signed((DbW+1)'(QuantOffset));
    lvl = '0;
    if (x > 0) begin
      lvl = ClipLevel;
    end else if (!t[DbW]) begin
      for (int k = 1; k <= int'(TopLevel); k++) begin
        if (t >= $signed((DbW+1)'(k * QuantStep))) begin
          lvl = LevelW'(k);
        end
      end
    end
    return lvl;
  endfunction

endpackage

/* src/lmph_if.sv */
// ----------------------------------------------------------------------------
// lmph_if: valid/ready channels of the level meter
// Sample/command channel into the block and meter message channel out of it.
// ----------------------------------------------------------------------------
interface lmph_in_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic [lmph_pkg::ChanW-1:0]          channel;
  logic                                new_poll;
  logic                                track_present;
  logic signed [lmph_pkg::DbW-1:0]     peak_left_db;
  logic signed [lmph_pkg::DbW-1:0]     peak_right_db;

  modport source (
    output valid, cmd, channel, new_poll, track_present, peak_left_db, peak_right_db,
    input  ready
  );
  modport sink (
    input  valid, cmd, channel, new_poll, track_present, peak_left_db, peak_right_db,
    output ready
  );
endinterface

interface lmph_out_if;
  logic                        valid;
  logic                        ready;
  logic [lmph_pkg::PortW-1:0]  port;
  logic [lmph_pkg::KeyW-1:0]   key;
  logic [lmph_pkg::PressW-1:0] pressure;
  logic                        last;

  modport source (
    output valid, port, key, pressure, last,
    input  ready
  );
  modport sink (
    input  valid, port, key, pressure, last,
    output ready
  );
endinterface

/* src/lmph_ram.sv */
// ----------------------------------------------------------------------------
// lmph_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lmph_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/lmph_queue.sv */
// ----------------------------------------------------------------------------
// lmph_queue: short FIFO between front and back end
// Decouples classification from the history update so each side stalls alone.
// ----------------------------------------------------------------------------
module lmph_queue #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule

/* src/lmph_front.sv */
// ----------------------------------------------------------------------------
// lmph_front: intake and classification
// Accept items, advance the history slot, quantize both sides and queue
// samples and clears; drop samples of absent ports.
// ----------------------------------------------------------------------------
module lmph_front #(
  parameter int CHANNELS   = 32,
  parameter int HOLD_POLLS = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  lmph_in_if.sink                    in_i,
  input  logic [lmph_pkg::CfgW-1:0]  port_enable_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output lmph_pkg::item_t            q_item_o
);

  localparam int SlotW = (HOLD_POLLS > 1) ? $clog2(HOLD_POLLS) : 1;

  logic [SlotW-1:0] slot_q, slot_d, slot_adv, slot_cur;
  logic             fire, advance, ch_ok, port_en;

  assign in_i.ready = !q_full_i;
  assign fire       = in_i.valid && in_i.ready;
  assign advance    = !in_i.cmd && in_i.new_poll;

  assign slot_adv = (slot_q == SlotW'(HOLD_POLLS - 1)) ? '0 : slot_q + 1'b1;
  assign slot_cur = advance ? slot_adv : slot_q;
  assign slot_d   = (fire && advance) ? slot_adv : slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign ch_ok   = (int'(in_i.channel) < CHANNELS);
  assign port_en = port_enable_i[in_i.channel[lmph_pkg::ChanW-1 -: lmph_pkg::PortW]];

  // Clears always go through; samples only for present channels.
  assign q_push_o = fire && (in_i.cmd || (ch_ok && port_en));

  always_comb begin
    q_item_o          = '0;
    q_item_o.is_clear = in_i.cmd;
    q_item_o.channel  = in_i.channel;
    q_item_o.slot     = lmph_pkg::SlotFieldW'(slot_cur);
    if (in_i.track_present) begin
      q_item_o.lvl_l = lmph_pkg::quantize(in_i.peak_left_db);
      q_item_o.lvl_r = lmph_pkg::quantize(in_i.peak_right_db);
    end
  end

endmodule

/* src/lmph_back.sv */
// ----------------------------------------------------------------------------
// lmph_back: history update and message issue
// Read the channel's history word, insert the new levels, take the held
// maximum, compare with the last pair sent and issue the message pair.
// ----------------------------------------------------------------------------
module lmph_back #(
  parameter int CHANNELS   = 32,
  parameter int HOLD_POLLS = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  lmph_pkg::item_t item_i,
  output logic            pop_o,
  lmph_out_if.source      out_o
);

  localparam int AddrW = $clog2(CHANNELS);
  localparam int LvlW  = lmph_pkg::LevelW;
  localparam int HistW = 2 * HOLD_POLLS * LvlW;
  localparam int WordW = HistW + lmph_pkg::PairW;

  lmph_pkg::back_state_e state_q, state_d;
  lmph_pkg::item_t       cur_q, cur_d;

  logic [CHANNELS-1:0]   vld_q, vld_d;
  logic [AddrW-1:0]      cur_addr;
  logic                  rd_en, wr_en;
  logic [WordW-1:0]      rdata, word, wdata;
  logic [HistW-1:0]      hist_new;
  logic [LvlW-1:0]       mx_l, mx_r, fld;
  logic [lmph_pkg::PairW-1:0] pair;
  logic                  differ, out_free, load;

  logic                  out_vld_q, out_vld_d, out_last_q, out_last_d;
  logic [lmph_pkg::PortW-1:0] out_port_q;
  logic [lmph_pkg::KeyW-1:0]  out_key_q;
  logic [LvlW-1:0]       out_lvl_l_q, out_lvl_r_q;

  assign cur_addr = AddrW'(cur_q.channel);

  lmph_ram #(
    .Width (WordW),
    .Depth (CHANNELS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cur_addr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (AddrW'(item_i.channel)),
    .rdata_o (rdata)
  );

  // Unwritten entries read as empty history and an unknown pair.
  assign word = vld_q[cur_addr] ? rdata : {lmph_pkg::UnknownPair, HistW'(0)};

  always_comb begin
    hist_new = word[HistW-1:0];
    for (int h = 0; h < HOLD_POLLS; h++) begin
      if (lmph_pkg::SlotFieldW'(h) == cur_q.slot) begin
        hist_new[h*LvlW +: LvlW]                = cur_q.lvl_l;
        hist_new[(HOLD_POLLS + h)*LvlW +: LvlW] = cur_q.lvl_r;
      end
    end
    mx_l = '0;
    mx_r = '0;
    for (int h = 0; h < HOLD_POLLS; h++) begin
      fld = hist_new[h*LvlW +: LvlW];
      if (fld > mx_l) mx_l = fld;
      fld = hist_new[(HOLD_POLLS + h)*LvlW +: LvlW];
      if (fld > mx_r) mx_r = fld;
    end
    pair   = {mx_l, mx_r};
    differ = (pair != word[WordW-1 -: lmph_pkg::PairW]);
    wdata  = {pair, hist_new};
  end

  assign out_free = !out_vld_q || (out_last_q && out_o.ready);

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    vld_d   = vld_q;
    pop_o   = 1'b0;
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    load    = 1'b0;
    case (state_q)
      lmph_pkg::BK_FETCH: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (item_i.is_clear) begin
            vld_d = '0;
          end else begin
            rd_en   = 1'b1;
            cur_d   = item_i;
            state_d = lmph_pkg::BK_UPDATE;
          end
        end
      end
      lmph_pkg::BK_UPDATE: begin
        // hold until the message pair has room
        if (!differ || out_free) begin
          wr_en           = 1'b1;
          vld_d[cur_addr] = 1'b1;
          load            = differ;
          state_d         = lmph_pkg::BK_FETCH;
        end
      end
      default: begin
        state_d = lmph_pkg::BK_FETCH;
      end
    endcase
  end

  always_comb begin
    out_vld_d  = out_vld_q;
    out_last_d = out_last_q;
    if (out_vld_q && out_o.ready) begin
      out_last_d = 1'b1;
      out_vld_d  = !out_last_q;
    end
    if (load) begin
      out_vld_d  = 1'b1;
      out_last_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lmph_pkg::BK_FETCH;
      vld_q      <= '0;
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      vld_q      <= vld_d;
      out_vld_q  <= out_vld_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (load) begin
      out_port_q  <= cur_q.channel[lmph_pkg::ChanW-1 -: lmph_pkg::PortW];
      out_key_q   <= cur_q.channel[lmph_pkg::KeyW-1:0];
      out_lvl_l_q <= mx_l;
      out_lvl_r_q <= mx_r;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.port     = out_port_q;
  assign out_o.key      = out_key_q;
  assign out_o.last     = out_last_q;
  assign out_o.pressure = out_last_q ? (lmph_pkg::RightFlag | lmph_pkg::PressW'(out_lvl_r_q))
                                     : lmph_pkg::PressW'(out_lvl_l_q);

endmodule

/* src/led_meter_peak_hold_core.sv */
// ----------------------------------------------------------------------------
// led_meter_peak_hold_core: peak-hold LED level meter, top level
// A sample's left message passes the queue, the history read and the output
//   register; the right message is offered from the edge the left is taken.
// Flow: a sample gets a history read, then update and write-back, before the
//   next item is fetched; a clear only the fetch state, an absent port none;
//   intake takes a transaction every cycle while the 2-entry queue has room.
// Reset: port enables all ones, history slot 0, every channel valid bit
//   cleared at once (empty history, unknown last pair); no clearing pass.
// ----------------------------------------------------------------------------
module led_meter_peak_hold_core #(
  parameter int CHANNELS   = 32,
  parameter int HOLD_POLLS = 3
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  lmph_in_if.sink                   in_i,
  lmph_out_if.source                out_o,
  input  logic                      cfg_we_i,
  input  logic [lmph_pkg::CfgW-1:0] cfg_wdata_i
);

  // Port enable register; write only while the block is quiet (unchecked).
  logic [lmph_pkg::CfgW-1:0] port_enable_q, port_enable_d;

  assign port_enable_d = cfg_we_i ? cfg_wdata_i : port_enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_enable_q <= lmph_pkg::PortEnRst;
    end else begin
      port_enable_q <= port_enable_d;
    end
  end

  // Front end: classify each transaction, quantize, track the history slot.
  logic            q_push, q_pop, q_full, q_empty;
  lmph_pkg::item_t q_in_item, q_out_item;

  lmph_front #(
    .CHANNELS   (CHANNELS),
    .HOLD_POLLS (HOLD_POLLS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .port_enable_i (port_enable_q),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (q_in_item)
  );

  // Queue: let intake run ahead while the back end waits on the output.
  lmph_queue #(
    .Width ($bits(lmph_pkg::item_t)),
    .Depth (lmph_pkg::QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in_item),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .data_o  (q_out_item)
  );

  // Back end: update history, hold the peak, issue the message pair.
  lmph_back #(
    .CHANNELS   (CHANNELS),
    .HOLD_POLLS (HOLD_POLLS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .item_i  (q_out_item),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

  // A shown level never exceeds the clip segment.
  ap_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.pressure[lmph_pkg::LevelW-1:0] <= lmph_pkg::ClipLevel))
    else $error("meter level above clip segment");

  // A taken left message is followed by the right one of the same channel.
  ap_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.last |=>
      out_o.valid && out_o.last && $stable(out_o.port) && $stable(out_o.key))
    else $error("right message does not follow left message");

  // A new message pair always opens with the left side.
  ap_pair_opens_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> !out_o.last)
    else $error("message pair opens with right side");

  // The queue is pushed while full only if it is popped in the same cycle.
  ap_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full || q_pop)
    else $error("queue overflow");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the peak-hold LED level meter
// Drives peak samples and clear commands over the valid/ready sample channel,
// keeps its own copy of the poll slot, segment history and last-sent pairs,
// and checks every meter message in order. A directed table comes first,
// then random poll rounds under several port enable settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int Channels     = 32;
  localparam int HoldPolls    = 3;
  localparam int SettleCycles = 8;      // queue of two plus the back end
  localparam int HoldCycles   = 400;    // long receiver hold-off
  localparam int CalmItems    = 150;    // tail of the run without idling
  localparam int CycleLimit   = 400000;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    ROW_SAMPLE,
    ROW_CLEAR,
    ROW_CFG
  } row_kind_e;

  typedef enum logic {
    CHK_MODEL,  // expectation from the predictor
    CHK_TYPED   // expectation typed into the row
  } row_check_e;

  typedef struct packed {
    logic                            cmd;
    logic [lmph_pkg::ChanW-1:0]      channel;
    logic                            new_poll;
    logic                            track_present;
    logic signed [lmph_pkg::DbW-1:0] left_db;
    logic signed [lmph_pkg::DbW-1:0] right_db;
  } sample_t;

  typedef struct packed {
    logic [lmph_pkg::PortW-1:0]  port;
    logic [lmph_pkg::KeyW-1:0]   key;
    logic [lmph_pkg::PressW-1:0] pressure;
    logic                        last;
  } meter_msg_t;

  typedef struct packed {
    row_kind_e                       kind;
    logic [lmph_pkg::ChanW-1:0]      channel;
    logic                            new_poll;
    logic                            track_present;
    logic signed [lmph_pkg::DbW-1:0] left_db;
    logic signed [lmph_pkg::DbW-1:0] right_db;
    logic [lmph_pkg::CfgW-1:0]       cfg;
    row_check_e                      chk;
    logic [1:0]                      n_exp;
    logic [lmph_pkg::LevelW-1:0]     exp_l;
    logic [lmph_pkg::LevelW-1:0]     exp_r;
  } dir_row_t;

  // Directed rows: extremes of the quantizer, unchanged pairs, trackless
  // channels, hold and decay over three polls, clear, and disabled ports.
  localparam int DirRows = 22;
  localparam dir_row_t DIRECTED [DirRows] = '{
    // 0 dB maps to 12.5 and saturates at the top segment
    '{ROW_SAMPLE, 5'd0,  1'b0, 1'b1, 17'sd0,     17'sd0,     4'h0, CHK_TYPED, 2'd2, 4'd11, 4'd11},
    // just above 0 dB clips, lowest stated level gives segment 0
    '{ROW_SAMPLE, 5'd1,  1'b0, 1'b1, 17'sd1,     -17'sd38400, 4'h0, CHK_TYPED, 2'd2, 4'd12, 4'd0},
    '{ROW_SAMPLE, 5'd2,  1'b0, 1'b1, 17'sd6144,  17'sd6144,  4'h0, CHK_TYPED, 2'd2, 4'd12, 4'd12},
    // no track: both sides forced to zero, still sent since pair is unknown
    '{ROW_SAMPLE, 5'd3,  1'b0, 1'b0, 17'sd6144,  17'sd6144,  4'h0, CHK_TYPED, 2'd2, 4'd0,  4'd0},
    // same pair as last sent: nothing goes out
    '{ROW_SAMPLE, 5'd0,  1'b0, 1'b1, 17'sd0,     17'sd0,     4'h0, CHK_TYPED, 2'd0, 4'd0,  4'd0},
    // segment edges around -60 dB
    '{ROW_SAMPLE, 5'd4,  1'b0, 1'b1, -17'sd15360, -17'sd14720, 4'h0, CHK_MODEL, 2'd0, 4'd0, 4'd0},
    '{ROW_SAMPLE, 5'd5,  1'b0, 1'b1, -17'sd16000, -17'sd16001, 4'h0, CHK_MODEL, 2'd0, 4'd0, 4'd0},
    // three polls of silence: held for two, dropped on the third
    '{ROW_SAMPLE, 5'd0,  1'b1, 1'b0, 17'sd0,     17'sd0,     4'h0, CHK_MODEL, 2'd0, 4'd0,  4'd0},
    '{ROW_SAMPLE, 5'd0,  1'b1, 1'b0, 17'sd0,     17'sd0,     4'h0, CHK_MODEL, 2'd0, 4'd0,  4'd0},
    '{ROW_SAMPLE, 5'd0,  1'b1, 1'b0, 17'sd0,     17'sd0,     4'h0, CHK_MODEL, 2'd0, 4'd0,  4'd0},
    '{ROW_SAMPLE, 5'd31, 1'b0, 1'b1, -17'sd1,    -17'sd2561, 4'h0, CHK_MODEL, 2'd0, 4'd0,  4'd0},
    // far outside the stated range on both sides
    '{ROW_SAMPLE, 5'd12, 1'b0, 1'b1, 17'h0FFFF,  17'h10000,  4'h0, CHK_MODEL, 2'd0, 4'd0,  4'd0},
    // clear with junk in the other fields, new poll included
    '{ROW_CLEAR,  5'd17, 1'b1, 1'b1, 17'h0FFFF,  -17'sd1,    4'h0, CHK_TYPED, 2'd0, 4'd0,  4'd0},
    '{ROW_SAMPLE, 5'd2,  1'b0, 1'b1, 17'sd6144,  17'sd6144,  4'h0, CHK_MODEL, 2'd0, 4'd0,  4'd0},
    // every port off: slot still advances, nothing comes out
    '{ROW_CFG,    5'd0,  1'b0, 1'b0, 17'sd0,     17'sd0,     4'h0, CHK_MODEL, 2'd0, 4'd0,  4'd0},
    '{ROW_SAMPLE, 5'd9,  1'b1, 1'b1, 17'sd0,     17'sd0,     4'h0, CHK_TYPED, 2'd0, 4'd0,  4'd0},
    '{ROW_CFG,    5'd0,  1'b0, 1'b0, 17'sd0,     17'sd0,     4'hA, CHK_MODEL, 2'd0, 4'd0,  4'd0},
    '{ROW_SAMPLE, 5'd8,  1'b0, 1'b1, -17'sd6400, -17'sd3840, 4'h0, CHK_MODEL, 2'd0, 4'd0,  4'd0},
    '{ROW_SAMPLE, 5'd16, 1'b1, 1'b1, 17'sd0,     17'sd0,     4'h0, CHK_TYPED, 2'd0, 4'd0,  4'd0},
    '{ROW_SAMPLE, 5'd24, 1'b0, 1'b1, 17'sd1,     17'sd1,     4'h0, CHK_TYPED, 2'd2, 4'd12, 4'd12},
    '{ROW_CFG,    5'd0,  1'b0, 1'b0, 17'sd0,     17'sd0,     4'hF, CHK_MODEL, 2'd0, 4'd0,  4'd0},
    '{ROW_SAMPLE, 5'd16, 1'b0, 1'b0, 17'sd0,     17'sd0,     4'h0, CHK_MODEL, 2'd0, 4'd0,  4'd0}
  };

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [lmph_pkg::CfgW-1:0] cfg_wdata_i;

  lmph_in_if  sample_if ();
  lmph_out_if meter_if ();

  led_meter_peak_hold_core #(
    .CHANNELS   (Channels),
    .HOLD_POLLS (HoldPolls)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (sample_if),
    .out_o       (meter_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Predictor state: shadow of the block's poll slot, history and cache.
  logic [lmph_pkg::CfgW-1:0]   port_en;
  int                          poll_slot;
  logic [lmph_pkg::LevelW-1:0] seg_hist [Channels][2][HoldPolls];
  logic [lmph_pkg::PairW-1:0]  last_pair [Channels];

  // Meter messages still owed by the block, oldest first.
  meter_msg_t meter_msgs_due [$];

  // Last level offered per channel and side, so the random part can repeat
  // it and produce unchanged pairs.
  logic signed [lmph_pkg::DbW-1:0] last_db [Channels][2];

  int unsigned mismatch_cnt;
  bit          calm;      // no idling on either side
  bit          hold_req;  // ask the receiver for a long hold-off

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Map a Q8.8 dB level to its LED segment: clip above 0 dB, otherwise
  // (dB + 62.5) / 5 rounded down and clamped to 0..11.
  function automatic logic [lmph_pkg::LevelW-1:0] db_to_segment(
      input logic signed [lmph_pkg::DbW-1:0] db);
    int t;
    if (db > 0) return lmph_pkg::ClipLevel;
    t = int'(db) + lmph_pkg::QuantOffset;
    if (t < 0) return '0;
    if (t / lmph_pkg::QuantStep > int'(lmph_pkg::TopLevel)) return lmph_pkg::TopLevel;
    return lmph_pkg::LevelW'(t / lmph_pkg::QuantStep);
  endfunction

  // Empty the history and mark every last-sent pair unknown.
  function automatic void forget_meters();
    for (int c = 0; c < Channels; c++) begin
      last_pair[c] = lmph_pkg::UnknownPair;
      for (int s = 0; s < 2; s++) begin
        for (int h = 0; h < HoldPolls; h++) seg_hist[c][s][h] = '0;
      end
    end
  endfunction

  // Advance the shadow state by one accepted transaction and return how many
  // meter messages it causes (0 or 2), with the pair in lm and rm.
  function automatic int step_meter(input sample_t s, output meter_msg_t lm,
                                    output meter_msg_t rm);
    logic [lmph_pkg::LevelW-1:0] held [2];
    logic [lmph_pkg::PairW-1:0]  pair;
    int                          ch;
    lm = '0;
    rm = '0;
    if (s.cmd == CMD_CLEAR) begin
      forget_meters();
      return 0;
    end
    if (s.new_poll) poll_slot = (poll_slot + 1) % HoldPolls;
    ch = int'(s.channel);
    if (!port_en[s.channel[lmph_pkg::ChanW-1:3]]) return 0;
    held[0] = s.track_present ? db_to_segment(s.left_db) : '0;
    held[1] = s.track_present ? db_to_segment(s.right_db) : '0;
    for (int side = 0; side < 2; side++) begin
      seg_hist[ch][side][poll_slot] = held[side];
      for (int h = 0; h < HoldPolls; h++) begin
        if (seg_hist[ch][side][h] > held[side]) held[side] = seg_hist[ch][side][h];
      end
    end
    pair = {held[0], held[1]};
    if (pair == last_pair[ch]) return 0;
    last_pair[ch] = pair;
    lm = '{port: s.channel[lmph_pkg::ChanW-1:3], key: s.channel[2:0],
           pressure: lmph_pkg::PressW'(held[0]), last: 1'b0};
    rm = '{port: s.channel[lmph_pkg::ChanW-1:3], key: s.channel[2:0],
           pressure: lmph_pkg::RightFlag | lmph_pkg::PressW'(held[1]), last: 1'b1};
    return 2;
  endfunction

  // Pick a level: mostly in range, with segment edges, the values around
  // 0 dB, repeats of the last level, and now and then any 17-bit pattern.
  function automatic logic signed [lmph_pkg::DbW-1:0] pick_db(input int ch,
                                                              input int side);
    logic signed [lmph_pkg::DbW-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = lmph_pkg::DbW'($urandom);
      1:       v = lmph_pkg::DbW'(int'($urandom_range(0, 12)) * lmph_pkg::QuantStep
                                  - lmph_pkg::QuantOffset
                                  + int'($urandom_range(0, 2)) - 1);
      2:       v = lmph_pkg::DbW'(int'($urandom_range(0, 2)) - 1);
      3, 4:    v = last_db[ch][side];
      default: v = lmph_pkg::DbW'(int'($urandom_range(0, 44544)) - 38400);
    endcase
    last_db[ch][side] = v;
    return v;
  endfunction

  // Offer one transaction, hold it until taken, then log what it owes.
  // A typed row overrides the predictor's messages with its own.
  task automatic send_sample(input sample_t s, input bit typed, input int typed_n,
                             input logic [lmph_pkg::LevelW-1:0] typed_l,
                             input logic [lmph_pkg::LevelW-1:0] typed_r);
    meter_msg_t lm, rm;
    int         n;
    if (!calm && !hold_req && $urandom_range(0, 4) == 0) begin
      sample_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    sample_if.valid         <= 1'b1;
    sample_if.cmd           <= s.cmd;
    sample_if.channel       <= s.channel;
    sample_if.new_poll      <= s.new_poll;
    sample_if.track_present <= s.track_present;
    sample_if.peak_left_db  <= s.left_db;
    sample_if.peak_right_db <= s.right_db;
    do @(posedge clk_i); while (!sample_if.ready);
    n = step_meter(s, lm, rm);
    if (typed) begin
      n  = typed_n;
      lm = '{port: s.channel[lmph_pkg::ChanW-1:3], key: s.channel[2:0],
             pressure: lmph_pkg::PressW'(typed_l), last: 1'b0};
      rm = '{port: s.channel[lmph_pkg::ChanW-1:3], key: s.channel[2:0],
             pressure: lmph_pkg::RightFlag | lmph_pkg::PressW'(typed_r), last: 1'b1};
    end
    if (n == 2) begin
      meter_msgs_due.push_back(lm);
      meter_msgs_due.push_back(rm);
    end
  endtask

  // Drop valid, wait for every owed message, then let trailing transactions
  // that cause no message work their way through the queue.
  task automatic drain_meter();
    sample_if.valid <= 1'b0;
    while (meter_msgs_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write the port enable register with the block idle.
  task automatic write_port_enable(input logic [lmph_pkg::CfgW-1:0] value);
    drain_meter();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    port_en = value;
    cfg_we_i <= 1'b0;
  endtask

  // Receiver: random bursts of ready and of stall, a long hold-off on
  // request, and ready held high once the run turns calm.
  initial begin : meter_sink
    int n;
    meter_if.ready = 1'b0;
    forever begin
      if (hold_req) begin
        meter_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        meter_if.ready <= 1'b0;
        n = $urandom_range(1, 15);
        repeat (n) @(posedge clk_i);
      end else begin
        meter_if.ready <= 1'b1;
        n = calm ? 1 : $urandom_range(1, 20);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // Compare each taken meter message with the oldest one owed.
  always @(posedge clk_i) begin : meter_check
    meter_msg_t got, want;
    if (rst_ni && meter_if.valid && meter_if.ready) begin
      got = '{port: meter_if.port, key: meter_if.key,
              pressure: meter_if.pressure, last: meter_if.last};
      if (meter_msgs_due.size() == 0) begin
        $error("meter message with none owed: port %0d key %0d pressure 0x%02h last %0b",
               got.port, got.key, got.pressure, got.last);
        mismatch_cnt++;
      end else begin
        want = meter_msgs_due.pop_front();
        if (got.port !== want.port) begin
          $error("port: expected %0d, got %0d", want.port, got.port);
          mismatch_cnt++;
        end
        if (got.key !== want.key) begin
          $error("key: expected %0d, got %0d", want.key, got.key);
          mismatch_cnt++;
        end
        if (got.pressure !== want.pressure) begin
          $error("pressure: expected 0x%02h, got 0x%02h", want.pressure, got.pressure);
          mismatch_cnt++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, got.last);
          mismatch_cnt++;
        end
      end
    end
  end

  // End the run if it hangs.
  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    dir_row_t                  row;
    sample_t                   stim;
    logic [lmph_pkg::CfgW-1:0] phase_en [6];
    int                        phase_len [6];
    int                        round_ch;
    int                        r;

    // Hold every input at a known value from time zero.
    rst_ni                  = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_wdata_i             = '0;
    sample_if.valid         = 1'b0;
    sample_if.cmd           = CMD_SAMPLE;
    sample_if.channel       = '0;
    sample_if.new_poll      = 1'b0;
    sample_if.track_present = 1'b0;
    sample_if.peak_left_db  = '0;
    sample_if.peak_right_db = '0;
    mismatch_cnt            = 0;
    calm                    = 1'b0;
    hold_req                = 1'b0;
    round_ch                = 0;

    port_en   = lmph_pkg::PortEnRst;
    poll_slot = 0;
    forget_meters();
    for (int c = 0; c < Channels; c++) begin
      last_db[c][0] = '0;
      last_db[c][1] = '0;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table.
    for (int i = 0; i < DirRows; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_CFG) begin
        write_port_enable(row.cfg);
      end else begin
        stim               = '0;
        stim.cmd           = (row.kind == ROW_CLEAR) ? CMD_CLEAR : CMD_SAMPLE;
        stim.channel       = row.channel;
        stim.new_poll      = row.new_poll;
        stim.track_present = row.track_present;
        stim.left_db       = row.left_db;
        stim.right_db      = row.right_db;
        send_sample(stim, row.chk == CHK_TYPED, int'(row.n_exp), row.exp_l, row.exp_r);
      end
    end

    // Random poll rounds, one port enable setting per phase. The all-off
    // phase stays short since it yields no messages.
    phase_en  = '{4'hF, 4'h0, lmph_pkg::CfgW'($urandom_range(1, 14)), 4'h1, 4'h8, 4'hF};
    phase_len = '{300, 60, 250, 200, 200, 320};

    for (int p = 0; p < 6; p++) begin
      write_port_enable(phase_en[p]);
      for (int i = 0; i < phase_len[p]; i++) begin
        // Stall the receiver long enough to back up the block's queue while
        // items keep coming, then pause the sender until all is delivered.
        if (p == 0 && i == 100) hold_req = 1'b1;
        if (p == 0 && i == 160) drain_meter();
        if (p == 5 && i == phase_len[p] - CalmItems) calm = 1'b1;

        stim = '0;
        r    = $urandom_range(0, 99);
        if (r < 2) begin
          // clear, with junk in the other fields
          stim.cmd           = CMD_CLEAR;
          stim.channel       = lmph_pkg::ChanW'($urandom);
          stim.new_poll      = 1'($urandom);
          stim.track_present = 1'($urandom);
          stim.left_db       = lmph_pkg::DbW'($urandom);
          stim.right_db      = lmph_pkg::DbW'($urandom);
        end else begin
          stim.cmd = CMD_SAMPLE;
          if (r < 8) begin
            // out-of-order channel with a stray poll flag
            stim.channel  = lmph_pkg::ChanW'($urandom);
            stim.new_poll = 1'($urandom);
          end else begin
            // advance through the round; wrap starts a new poll
            round_ch += $urandom_range(1, 3);
            if (round_ch > Channels - 1) begin
              round_ch      = $urandom_range(0, 3);
              stim.new_poll = 1'b1;
            end
            stim.channel = lmph_pkg::ChanW'(round_ch);
          end
          stim.track_present = ($urandom_range(0, 9) != 0);
          stim.left_db       = pick_db(int'(stim.channel), 0);
          stim.right_db      = pick_db(int'(stim.channel), 1);
        end
        send_sample(stim, 1'b0, 0, '0, '0);
      end
    end

    drain_meter();
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
src/lmph_pkg.sv
src/lmph_if.sv
src/lmph_ram.sv
src/lmph_queue.sv
src/lmph_front.sv
src/lmph_back.sv
src/led_meter_peak_hold_core.sv
sim/tb_top.sv
